// File: rtl/lz_match_copy_engine_assert.svh
// Assertion macros for the LZ77 match copy engine.
// Used by rtl/lz_match_copy_engine.sv; no other dependencies.
`ifndef LZ_MATCH_COPY_ENGINE_ASSERT_SVH
`define LZ_MATCH_COPY_ENGINE_ASSERT_SVH

`ifndef ASSERT_OFF

// Clocked check, masked while reset is asserted
`define LZMC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked check that also holds during reset
`define LZMC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define LZMC_ASSERT(lbl, clk, rst_n, prop, msg)

`define LZMC_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// File: rtl/lzmc_pkg.sv
// Shared types and constants of the LZ77 match copy engine.
// No dependencies; used by the top level and the window RAM instance.
package lzmc_pkg;

    // Window and run sizes
    localparam int unsigned WINDOW_SIZE = 32768;
    localparam int unsigned MAX_RUN     = 64;

    // Field widths
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned OFF_W  = 16;
    localparam int unsigned LEN_W  = 7;

    // Derived widths
    localparam int unsigned ADDR_W = $clog2(WINDOW_SIZE);
    localparam int unsigned HELD_W = $clog2(WINDOW_SIZE + 1);
    localparam int unsigned LEFT_W = $clog2(MAX_RUN + 1);
    localparam int unsigned CMP_W  = ((HELD_W > OFF_W) ? HELD_W : OFF_W) + 1;

    // Command codes
    localparam logic CMD_LITERAL = 1'b0;
    localparam logic CMD_MATCH   = 1'b1;

    // Input beat
    typedef struct packed {
        logic              command;
        logic [BYTE_W-1:0] literal_byte;
        logic [OFF_W-1:0]  match_offset;
        logic [LEN_W-1:0]  match_length;
    } t_in_beat;

    // Output beat
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_of_run;
        logic              bad_offset;
    } t_out_beat;

endpackage

// File: rtl/lzmc_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module lzmc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write, and read with the data held until the next read enable
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/lz_match_copy_engine.sv
// LZ77 match copy engine top level: window RAM, copy sequencer, output register.
// Depends on lzmc_pkg, lzmc_ram and lz_match_copy_engine_assert.svh.
//
// Expands literal and match beats into decoded bytes through a 32 KiB history
// window held in one RAM. A literal beat gives one byte. A match beat of length L
// (clamped to 64) is accepted, then gives one byte per cycle through the window
// RAM read port while the output is not stalled; output stalls hold the run. A
// match with a bad offset gives one bad_offset beat; a match of length zero gives
// nothing. A new input beat is taken only when the previous match has emitted its
// last byte and the output register can be loaded. Overlapping copies forward the
// byte being written when the read address equals the write address (an offset
// of one). The window needs no clearing after reset: the offset check keeps reads
// within bytes already written.
`include "lz_match_copy_engine_assert.svh"

module lz_match_copy_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lzmc_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lzmc_pkg::t_out_beat o_out_data
);

    localparam int unsigned ADDR_W = lzmc_pkg::ADDR_W;
    localparam int unsigned HELD_W = lzmc_pkg::HELD_W;
    localparam int unsigned LEFT_W = lzmc_pkg::LEFT_W;
    localparam int unsigned CMP_W  = lzmc_pkg::CMP_W;
    localparam int unsigned BYTE_W = lzmc_pkg::BYTE_W;

    // Window position and fill
    logic [ADDR_W-1:0] r_wp;
    logic [HELD_W-1:0] r_held;

    // Copy sequencer
    logic [ADDR_W-1:0] r_src;
    logic [LEFT_W-1:0] r_left;
    logic              r_pend;
    logic              r_pend_last;
    logic              r_fwd;
    logic [BYTE_W-1:0] r_last_byte;

    // Output register
    logic                r_out_valid;
    lzmc_pkg::t_out_beat r_out;
    lzmc_pkg::t_out_beat n_out;

    logic              in_acc;
    logic              is_lit;
    logic              len_zero;
    logic              off_bad;
    logic              start_match;
    logic              load_bad;
    logic              out_free;
    logic              emit;
    logic              issue;
    logic              out_load;
    logic [BYTE_W-1:0] ram_rdata;
    logic [BYTE_W-1:0] emit_byte;
    logic              ram_we;
    logic [BYTE_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] wp_next;
    logic [HELD_W-1:0] held_next;
    logic [ADDR_W-1:0] src_next;
    logic [ADDR_W-1:0] src_start;
    logic [LEFT_W-1:0] len_sat;
    logic [CMP_W-1:0]  off_cmp;
    logic [CMP_W-1:0]  wp_cmp;

    // Handshake and sequencer strobes
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_left == '0) && !r_pend && out_free;
    assign in_acc      = i_in_valid && o_in_ready;
    assign emit        = r_pend && out_free;
    assign issue       = (r_left != '0) && (!r_pend || emit);

    // Decode the input beat
    assign is_lit      = (i_in_data.command == lzmc_pkg::CMD_LITERAL);
    assign len_zero    = (i_in_data.match_length == '0);
    assign off_cmp     = CMP_W'(i_in_data.match_offset);
    assign wp_cmp      = CMP_W'(r_wp);
    assign off_bad     = (i_in_data.match_offset == '0) || (off_cmp > CMP_W'(r_held));
    assign start_match = in_acc && !is_lit && !len_zero && !off_bad;
    assign load_bad    = in_acc && !is_lit && !len_zero && off_bad;
    assign out_load    = emit || load_bad || (in_acc && is_lit);

    // Clamp the run length
    assign len_sat = (i_in_data.match_length > lzmc_pkg::LEN_W'(lzmc_pkg::MAX_RUN))
                   ? LEFT_W'(lzmc_pkg::MAX_RUN)
                   : LEFT_W'(i_in_data.match_length);

    // Source address of the first copied byte, modulo the window
    assign src_start = (wp_cmp >= off_cmp)
                     ? ADDR_W'(wp_cmp - off_cmp)
                     : ADDR_W'(wp_cmp + CMP_W'(lzmc_pkg::WINDOW_SIZE) - off_cmp);

    // Advance pointers with wrap; saturate the fill
    assign wp_next   = (r_wp == ADDR_W'(lzmc_pkg::WINDOW_SIZE - 1)) ? '0 : r_wp + ADDR_W'(1);
    assign src_next  = (r_src == ADDR_W'(lzmc_pkg::WINDOW_SIZE - 1)) ? '0 : r_src + ADDR_W'(1);
    assign held_next = (r_held == HELD_W'(lzmc_pkg::WINDOW_SIZE))
                     ? r_held : r_held + HELD_W'(1);

    // Pick the copied byte, forwarding a same-address write
    assign emit_byte = r_fwd ? r_last_byte : ram_rdata;
    assign ram_we    = emit || (in_acc && is_lit);
    assign ram_wdata = emit ? emit_byte : i_in_data.literal_byte;

    lzmc_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (lzmc_pkg::WINDOW_SIZE)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata (ram_wdata),
        .i_re    (issue),
        .i_raddr (r_src),
        .o_rdata (ram_rdata)
    );

    // Select the next output beat
    always_comb begin
        n_out = r_out;
        priority if (emit) begin
            n_out.out_byte    = emit_byte;
            n_out.last_of_run = r_pend_last;
            n_out.bad_offset  = 1'b0;
        end else if (load_bad) begin
            n_out.out_byte    = '0;
            n_out.last_of_run = 1'b1;
            n_out.bad_offset  = 1'b1;
        end else if (in_acc && is_lit) begin
            n_out.out_byte    = i_in_data.literal_byte;
            n_out.last_of_run = 1'b1;
            n_out.bad_offset  = 1'b0;
        end
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_held      <= '0;
            r_left      <= '0;
            r_pend      <= 1'b0;
            r_fwd       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (ram_we) begin
                r_wp   <= wp_next;
                r_held <= held_next;
            end
            if (start_match) begin
                r_left <= len_sat;
            end else if (issue) begin
                r_left <= r_left - LEFT_W'(1);
            end
            if (issue) begin
                r_pend <= 1'b1;
                r_fwd  <= emit && (r_wp == r_src);
            end else if (emit) begin
                r_pend <= 1'b0;
                r_fwd  <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold payload state
    always_ff @(posedge i_clk) begin
        if (start_match) begin
            r_src <= src_start;
        end else if (issue) begin
            r_src <= src_next;
        end
        if (issue) begin
            r_pend_last <= (r_left == LEFT_W'(1));
        end
        if (emit) begin
            r_last_byte <= emit_byte;
        end
        if (out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Checks on the copy sequencer
    `LZMC_ASSERT(a_accept_idle, i_clk, i_rst_n, (in_acc |-> (r_left == '0 && !r_pend)),
        "input beat accepted during a run")
    `LZMC_ASSERT(a_held_limit, i_clk, i_rst_n, (r_held <= HELD_W'(lzmc_pkg::WINDOW_SIZE)),
        "fill count above window size")
    `LZMC_ASSERT(a_fwd_pend, i_clk, i_rst_n, (r_fwd |-> r_pend),
        "forward flag without a pending read")
    `LZMC_ASSERT(a_bad_beat, i_clk, i_rst_n,
        ((r_out_valid && r_out.bad_offset) |-> (r_out.out_byte == '0 && r_out.last_of_run)),
        "bad_offset beat malformed")
    `LZMC_ASSERT(a_emit_adv, i_clk, i_rst_n, (emit |=> (r_wp != $past(r_wp))),
        "window position did not advance on a copied byte")

endmodule

// File: tb/lzmc_checker.sv
`timescale 1ns / 100ps
// Scoreboard for lz_match_copy_engine: watches both channels, expands every accepted
// command into its decoded bytes and compares them with the output beats.
// Depends on lzmc_pkg.
module lzmc_checker
    import lzmc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_beat  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_beat i_out_data,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_beats_checked
);

    // Shadow copy of the history window and its pointers
    logic [BYTE_W-1:0] history_mem [WINDOW_SIZE];
    logic [ADDR_W-1:0] next_slot;
    logic [HELD_W-1:0] held_cnt;

    // Decoded bytes still owed by the block, oldest first
    t_out_beat decoded_bytes_q [$];

    int fail_cnt    = 0;
    int checked_cnt = 0;

    task automatic report_fail(input string msg);
        if (fail_cnt < 10) begin
            $display("%0t MISMATCH: %s", $time, msg);
        end
        fail_cnt++;
    endtask

    task automatic push_decoded(input logic [BYTE_W-1:0] value, input logic last,
                                input logic bad);
        t_out_beat beat;
        beat.out_byte    = value;
        beat.last_of_run = last;
        beat.bad_offset  = bad;
        decoded_bytes_q.push_back(beat);
    endtask

    // Write one byte at the head of the window; held count saturates at the window size
    task automatic append_byte(input logic [BYTE_W-1:0] value);
        history_mem[next_slot] = value;
        next_slot = next_slot + 1'b1;
        if (held_cnt < WINDOW_SIZE) begin
            held_cnt = held_cnt + 1'b1;
        end
    endtask

    // Expand one command into the bytes it decodes to
    task automatic expand_command(input t_in_beat cmd);
        int unsigned       run_len;
        logic [ADDR_W-1:0] src;
        logic [BYTE_W-1:0] value;
        if (cmd.command == CMD_LITERAL) begin
            append_byte(cmd.literal_byte);
            push_decoded(cmd.literal_byte, 1'b1, 1'b0);
        end else if (cmd.match_length != '0) begin
            run_len = (cmd.match_length > MAX_RUN) ? MAX_RUN : cmd.match_length;
            if (cmd.match_offset == '0 || cmd.match_offset > held_cnt) begin
                push_decoded('0, 1'b1, 1'b1);
            end else begin
                // Copy byte by byte so that overlapping runs repeat the pattern
                for (int i = 0; i < run_len; i++) begin
                    src   = next_slot - cmd.match_offset[ADDR_W-1:0];
                    value = history_mem[src];
                    append_byte(value);
                    push_decoded(value, (i == run_len - 1), 1'b0);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin : watch_proc
        t_out_beat want;
        if (!i_rst_n) begin
            next_slot = '0;
            held_cnt  = '0;
            decoded_bytes_q.delete();
        end else begin
            // Compare the output beat with the oldest decoded byte
            if (i_out_valid && i_out_ready) begin
                if (decoded_bytes_q.size() == 0) begin
                    report_fail($sformatf("unexpected beat byte=%02h last=%0b bad=%0b",
                                          i_out_data.out_byte, i_out_data.last_of_run,
                                          i_out_data.bad_offset));
                end else begin
                    want = decoded_bytes_q.pop_front();
                    if (want.out_byte !== i_out_data.out_byte) begin
                        report_fail($sformatf("beat %0d out_byte exp %02h got %02h",
                                              checked_cnt, want.out_byte,
                                              i_out_data.out_byte));
                    end
                    if (want.last_of_run !== i_out_data.last_of_run) begin
                        report_fail($sformatf("beat %0d last_of_run exp %0b got %0b",
                                              checked_cnt, want.last_of_run,
                                              i_out_data.last_of_run));
                    end
                    if (want.bad_offset !== i_out_data.bad_offset) begin
                        report_fail($sformatf("beat %0d bad_offset exp %0b got %0b",
                                              checked_cnt, want.bad_offset,
                                              i_out_data.bad_offset));
                    end
                end
                checked_cnt++;
            end
            // Predict what the accepted command decodes to
            if (i_in_valid && i_in_ready) begin
                expand_command(i_in_data);
            end
        end
        o_pending       <= decoded_bytes_q.size();
        o_fail_count    <= fail_cnt;
        o_beats_checked <= checked_cnt;
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Top of the lz_match_copy_engine testbench: clock, reset, command stimulus,
// output back-pressure and the verdict. Depends on lzmc_pkg and lzmc_checker.
module tb_top;
    import lzmc_pkg::*;

    localparam int LIMIT_CYCLES = 500000;
    localparam int RANDOM_ITEMS = 290;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 100;
    localparam int IDLE_PCT     = 38;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_beat  i_in_data   = '0;
    logic      i_out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_beat o_out_data;

    int fail_count;
    int pending_cnt;
    int beats_checked;

    // Stimulus bookkeeping
    int stim_held  = 0;
    int n_literal  = 0;
    int n_match    = 0;
    int n_bad      = 0;
    int n_zero     = 0;
    int cycle_cnt  = 0;
    bit quiet      = 1'b0;
    bit hold_request = 1'b0;

    always #10 i_clk = ~i_clk;

    lz_match_copy_engine DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    lzmc_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_in_data       (i_in_data),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_out_data      (o_out_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending_cnt),
        .o_beats_checked (beats_checked)
    );

    // End the run if it hangs
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d beats still owed", cycle_cnt,
                     pending_cnt);
            $display("Some tests failed");
            $finish;
        end
    end

    // Output side: random stalls, a quiet stretch and one long hold-off
    initial begin : receiver
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                i_out_ready <= 1'b0;
                hold_left--;
            end else if (hold_request && !hold_done) begin
                hold_done   = 1'b1;
                hold_left   = HOLD_CYCLES - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    function automatic t_in_beat make_beat(input logic cmd, input logic [BYTE_W-1:0] lit,
                                           input logic [OFF_W-1:0] off,
                                           input logic [LEN_W-1:0] len);
        t_in_beat b;
        b.command      = cmd;
        b.literal_byte = lit;
        b.match_offset = off;
        b.match_length = len;
        return b;
    endfunction

    // Track how much history the block holds, so offsets can be aimed
    task automatic note_item(input t_in_beat b);
        int run_len;
        if (b.command == CMD_LITERAL) begin
            n_literal++;
            stim_held++;
        end else if (b.match_length == '0) begin
            n_zero++;
        end else if (b.match_offset == '0 || b.match_offset > stim_held) begin
            n_bad++;
        end else begin
            n_match++;
            run_len   = (b.match_length > MAX_RUN) ? MAX_RUN : b.match_length;
            stim_held = stim_held + run_len;
        end
        if (stim_held > WINDOW_SIZE) begin
            stim_held = WINDOW_SIZE;
        end
    endtask

    // Offer one beat, with random idle cycles ahead of it, and hold it until taken
    task automatic send_beat(input t_in_beat b);
        note_item(b);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Stop offering and wait until every owed beat has come out
    task automatic drain_outputs();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_cnt != 0) @(posedge i_clk);
    endtask

    // Mostly well-formed matches into held history, plus literals and broken items
    function automatic t_in_beat random_item();
        int unsigned pick;
        int unsigned reach;
        int unsigned top;
        t_in_beat    b;
        b.command      = CMD_MATCH;
        b.literal_byte = BYTE_W'($urandom_range(255));
        b.match_offset = OFF_W'($urandom_range(65535));
        b.match_length = LEN_W'($urandom_range(127));
        pick = $urandom_range(99);
        if (pick < 35 || stim_held == 0) begin
            b.command = CMD_LITERAL;
        end else if (pick < 80 || pick >= 93) begin
            reach = $urandom_range(99);
            if (reach < 50) begin
                top = (stim_held < 8) ? stim_held : 8;
            end else if (reach < 80) begin
                top = (stim_held < 64) ? stim_held : 64;
            end else begin
                top = stim_held;
            end
            b.match_offset = OFF_W'($urandom_range(top, 1));
            if (pick >= 93) begin
                b.match_length = LEN_W'($urandom_range(127, MAX_RUN + 1));
            end else if ($urandom_range(99) < 70) begin
                b.match_length = LEN_W'($urandom_range(16, 1));
            end else begin
                b.match_length = LEN_W'($urandom_range(MAX_RUN, 1));
            end
        end else if (pick < 88) begin
            b.match_offset = $urandom_range(1) ? '0
                           : OFF_W'($urandom_range(65535, stim_held + 1));
            b.match_length = LEN_W'($urandom_range(127, 1));
        end else begin
            b.match_length = '0;
        end
        return b;
    endfunction

    initial begin : stimulus
        t_in_beat b;
        int       real_cnt;
        int       idx;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty history, literal extremes, overlaps, saturation, bad offsets
        send_beat(make_beat(CMD_MATCH,   8'h3C, 16'd1,    7'd1));
        send_beat(make_beat(CMD_LITERAL, 8'h00, 16'd0,    7'd0));
        send_beat(make_beat(CMD_LITERAL, 8'hFF, 16'hFFFF, 7'h7F));
        send_beat(make_beat(CMD_LITERAL, 8'hA5, 16'h5555, 7'h2A));
        send_beat(make_beat(CMD_LITERAL, 8'h5A, 16'hAAAA, 7'h55));
        send_beat(make_beat(CMD_MATCH,   8'hFF, 16'd1,    7'd1));
        send_beat(make_beat(CMD_MATCH,   8'h00, 16'd1,    LEN_W'(MAX_RUN)));
        send_beat(make_beat(CMD_MATCH,   8'h81, 16'd3,    7'd10));
        send_beat(make_beat(CMD_MATCH,   8'h00, 16'd1,    7'd0));
        send_beat(make_beat(CMD_MATCH,   8'h00, 16'd0,    7'd0));
        send_beat(make_beat(CMD_MATCH,   8'h00, 16'd0,    7'd5));
        send_beat(make_beat(CMD_MATCH,   8'h00, OFF_W'(stim_held), 7'd5));
        send_beat(make_beat(CMD_MATCH,   8'h00, OFF_W'(stim_held + 1), 7'd5));
        send_beat(make_beat(CMD_MATCH,   8'hFF, 16'hFFFF, 7'h7F));
        send_beat(make_beat(CMD_MATCH,   8'h00, 16'd2,    7'h7F));
        send_beat(make_beat(CMD_MATCH,   8'h00, 16'd2,    LEN_W'(MAX_RUN + 1)));
        send_beat(make_beat(CMD_MATCH,   8'h00, 16'd10,   7'd3));
        send_beat(make_beat(CMD_MATCH,   8'h00, 16'h8000, 7'd1));
        send_beat(make_beat(CMD_LITERAL, 8'h55, 16'h0000, 7'h00));
        send_beat(make_beat(CMD_MATCH,   8'h00, 16'h7FFF, LEN_W'(MAX_RUN)));
        send_beat(make_beat(CMD_MATCH,   8'h00, OFF_W'(stim_held), 7'h7F));

        // Random part; zero-length matches do not count toward the total
        real_cnt = 0;
        idx      = 0;
        while (real_cnt < RANDOM_ITEMS) begin
            if (idx == 60) begin
                hold_request = 1'b1;
            end
            quiet = (idx >= 100 && idx < 160);
            if (idx == 220) begin
                drain_outputs();
            end
            b = random_item();
            send_beat(b);
            if (!(b.command == CMD_MATCH && b.match_length == '0)) begin
                real_cnt++;
            end
            idx++;
        end

        drain_outputs();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d literals, %0d good matches, %0d bad-offset and %0d empty matches",
                 n_literal, n_match, n_bad, n_zero);
        $display("Compared %0d output beats over a %0d-cycle hold-off and a mid-run drain",
                 beats_checked, HOLD_CYCLES);
        if (fail_count == 0 && pending_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: lz_match_copy_engine.f
+incdir+rtl
rtl/lzmc_pkg.sv
rtl/lzmc_ram.sv
rtl/lz_match_copy_engine.sv
tb/lzmc_checker.sv
tb/tb_top.sv
